### src/sem_pkg.sv
// sem_pkg: shared constants and types of the sobel edge magnitude block
// no dependencies; used by every module under src

package sem_pkg;

   // configuration defaults and limits
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MIN_WIDTH         = 3;
   localparam int LINE_WIDTH_W      = 12;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd1920;

   // register map: word index of each register
   localparam logic REG_LINE_WIDTH = 1'b0;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // saturated magnitude
   localparam logic [7:0] MAG_MAX = 8'd255;

   // one classified request handed from front to back
   typedef struct packed {
      logic [7:0] two_lines;
      logic [7:0] one_line;
      logic [7:0] pixel;
      logic       window_full;
   } item_type;

endpackage

### src/sem_front.sv
// sem_front: request intake, line history memory, pointer and fill tracking
// depends on sem_pkg; feeds sem_queue with one item_type per request

module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int QDEPTH    = sem_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sem_pkg::LINE_WIDTH_W-1:0]    line_width,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_pixel,
   input  logic [$clog2(QDEPTH+1)-1:0]         queue_count,
   output logic                                push,
   output sem_pkg::item_type                   push_item
);

   localparam int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int CW         = (WW > sem_pkg::LINE_WIDTH_W) ? WW : sem_pkg::LINE_WIDTH_W;
   localparam int FILL_LIMIT = 2 * MAX_WIDTH + 3;
   localparam int FW         = $clog2(FILL_LIMIT + 1);
   localparam int QCW        = $clog2(QDEPTH + 1);

   // history rows: upper byte two lines back, lower byte one line back
   logic [15:0] hist_mem [MAX_WIDTH];

   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          s1_valid_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [7:0]    s1_pixel_ff;
   logic          s1_full_ff;
   logic [15:0]   rd_row_ff;

   logic [CW-1:0] lw_ext, w_clamped;
   logic [WW-1:0] eff_width;
   logic [AW-1:0] cur_ptr;
   logic [WW-1:0] ptr_plus;
   logic          accept;
   logic          full_now;
   logic [QCW:0]  pending;

   // effective line width clamped to the supported range
   always_comb begin
      lw_ext = CW'(line_width);
      if (lw_ext < CW'(sem_pkg::MIN_WIDTH)) begin
         w_clamped = CW'(sem_pkg::MIN_WIDTH);
      end else if (lw_ext > CW'(MAX_WIDTH)) begin
         w_clamped = CW'(MAX_WIDTH);
      end else begin
         w_clamped = lw_ext;
      end
      eff_width = WW'(w_clamped);
   end

   // room check: queue entries plus the request in flight
   assign pending   = {1'b0, queue_count} + (QCW+1)'(s1_valid_ff);
   assign req_ready = !clr_busy_ff && (pending < (QCW+1)'(QDEPTH));
   assign accept    = req_valid && req_ready;

   // pointer wrap and fill count
   always_comb begin
      cur_ptr  = (WW'(ptr_ff) >= eff_width) ? '0 : ptr_ff;
      ptr_plus = WW'(cur_ptr) + WW'(1);
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      if (accept) begin
         ptr_in = (ptr_plus >= eff_width) ? '0 : AW'(ptr_plus);
         if (fill_ff < FW'(FILL_LIMIT)) begin
            fill_in = fill_ff + FW'(1);
         end
      end
      full_now = fill_in >= (FW'({eff_width, 1'b0}) + FW'(3));
   end

   // clearing pass over the history after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= accept;
      end
   end

   // request held for the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= cur_ptr;
         s1_pixel_ff <= req_pixel;
         s1_full_ff  <= full_now;
      end
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         hist_mem[clr_addr_ff] <= '0;
      end else if (s1_valid_ff) begin
         hist_mem[s1_addr_ff] <= {rd_row_ff[7:0], s1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= hist_mem[cur_ptr];
      end
   end

   // classified item into the queue
   assign push                  = s1_valid_ff;
   assign push_item.two_lines   = rd_row_ff[15:8];
   assign push_item.one_line    = rd_row_ff[7:0];
   assign push_item.pixel       = s1_pixel_ff;
   assign push_item.window_full = s1_full_ff;

endmodule

### src/sem_queue.sv
// sem_queue: short first-in first-out queue of item_type between front and back
// depends on sem_pkg

module sem_queue #(
   parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sem_pkg::item_type            push_item,
   input  logic                         pop,
   output sem_pkg::item_type            pop_item,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sem_pkg::item_type slots_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slots_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

### src/sem_back.sv
// sem_back: 3x3 window, sobel gradients, squares and iterative square root
// depends on sem_pkg; drains sem_queue and drives the response register

module sem_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  sem_pkg::item_type  queue_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_magnitude,
   output logic               rsp_window_full
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GRAD = 5'b00010,
      ST_SQR  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]         win_ff [3][3];
   logic               full_ff;
   logic signed [11:0] gx_ff, gy_ff;
   logic               sat_ff;
   logic [15:0]        val_ff;
   logic [11:0]        rem_ff;
   logic [7:0]         root_ff;
   logic [2:0]         step_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_mag_ff;
   logic               out_full_ff;

   logic signed [11:0] gx_c, gy_c;
   logic signed [23:0] gx_sq, gy_sq;
   logic [20:0]        sum_sq;
   logic [11:0]        rem_t, trial;
   logic               out_load;

   assign pop      = (state_ff == ST_IDLE) && !queue_empty;
   assign out_load = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_ready);

   // sobel kernels over the current window
   always_comb begin
      gx_c = (12'(win_ff[0][2]) - 12'(win_ff[0][0]))
           + ((12'(win_ff[1][2]) - 12'(win_ff[1][0])) <<< 1)
           + (12'(win_ff[2][2]) - 12'(win_ff[2][0]));
      gy_c = (12'(win_ff[2][0]) + (12'(win_ff[2][1]) <<< 1) + 12'(win_ff[2][2]))
           - (12'(win_ff[0][0]) + (12'(win_ff[0][1]) <<< 1) + 12'(win_ff[0][2]));
   end

   // squared gradients
   assign gx_sq  = gx_ff * gx_ff;
   assign gy_sq  = gy_ff * gy_ff;
   assign sum_sq = gx_sq[20:0] + gy_sq[20:0];

   // one restoring square root step
   assign rem_t = {rem_ff[9:0], val_ff[15:14]};
   assign trial = {2'b00, root_ff, 2'b01};

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!queue_empty) state_in = ST_GRAD;
         ST_GRAD: state_in = ST_SQR;
         ST_SQR:  state_in = ST_ROOT;
         ST_ROOT: if (step_ff == 3'd7) state_in = ST_HOLD;
         ST_HOLD: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // window shift on each new request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (pop) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= queue_item.two_lines;
         win_ff[1][2] <= queue_item.one_line;
         win_ff[2][2] <= queue_item.pixel;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         full_ff <= queue_item.window_full;
      end
      if (state_ff == ST_GRAD) begin
         gx_ff <= gx_c;
         gy_ff <= gy_c;
      end
      if (state_ff == ST_SQR) begin
         sat_ff  <= (sum_sq[20:16] != 5'd0);
         val_ff  <= sum_sq[15:0];
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_ROOT) begin
         val_ff  <= {val_ff[13:0], 2'b00};
         step_ff <= step_ff + 3'd1;
         if (rem_t >= trial) begin
            rem_ff  <= rem_t - trial;
            root_ff <= {root_ff[6:0], 1'b1};
         end else begin
            rem_ff  <= rem_t;
            root_ff <= {root_ff[6:0], 1'b0};
         end
      end
      if (out_load) begin
         out_mag_ff  <= sat_ff ? sem_pkg::MAG_MAX : root_ff;
         out_full_ff <= full_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_magnitude   = out_mag_ff;
   assign rsp_window_full = out_full_ff;

endmodule

### src/sobel_edge_magnitude.sv
// sobel_edge_magnitude: top level, csr port, front, queue and back
// depends on sem_pkg, sem_front, sem_queue, sem_back
//
//  channel   direction  tdata / data              tuser
//  req_      in         [7:0] pixel               -
//  rsp_      out        [7:0] magnitude           [0] window_full
//  csr_      in/out     [11:0] line_width @ 0x0   -
//
// in the back part a pixel passes through a window shift, a gradient step, a
// squaring step, eight square root steps and a load of the response register.
// the square root unit sets the rate. the front takes a request every cycle
// while the queue has room and runs ahead of the back. after reset the front
// clears the line history, one row per cycle over all MAX_WIDTH rows, with
// req_tready low; csr writes are taken throughout.

module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] magnitude
   output logic        rsp_tuser,    // [0] window_full
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int QCW = $clog2(sem_pkg::QUEUE_DEPTH + 1);

   logic [sem_pkg::LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   logic              csr_write;
   logic              push, pop, queue_empty;
   sem_pkg::item_type push_item, pop_item;
   logic [QCW-1:0]    queue_count;

   // register write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_write && (csr_paddr[2] == sem_pkg::REG_LINE_WIDTH)) begin
         line_width_in = csr_pwdata[sem_pkg::LINE_WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= sem_pkg::LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == sem_pkg::REG_LINE_WIDTH) begin
         csr_prdata = 32'(line_width_ff);
      end
   end

   // request intake and line history
   sem_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .QDEPTH    (sem_pkg::QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .line_width  (line_width_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_pixel   (req_tdata),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   // queue between front and back
   sem_queue #(
      .DEPTH (sem_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   // gradient and magnitude
   sem_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_item      (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_magnitude   (rsp_tdata),
      .rsp_window_full (rsp_tuser)
   );

endmodule

### verif/tb.sv
// tb: self-checking bench for sobel_edge_magnitude, pixel stream in, magnitudes out
// depends on sem_pkg and the sobel_edge_magnitude rtl under src

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = sem_pkg::MAX_WIDTH_DEFAULT;
   localparam int FILL_LIMIT = 2 * MAX_W + 3;
   localparam int ITEM_TARGET = 1200;
   localparam int DRAIN_LIMIT = 5000;
   localparam int QUIET_CYCLES = 24;
   localparam logic [2:0] CSR_LINE_WIDTH_ADDR = {sem_pkg::REG_LINE_WIDTH, 2'b00};

   typedef struct packed {
      logic [7:0] magnitude;
      logic       window_full;
   } magnitude_type;

   typedef struct packed {
      logic [7:0]    pixel;
      logic          typed;
      magnitude_type result;
   } directed_row_type;

   typedef enum int {PX_NOISE, PX_SMOOTH, PX_STEPS, PX_BINARY} pixel_style_type;

   // directed requests at line width 3; typed results only where obvious
   localparam int DIRECTED_ROWS = 22;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      {8'd0,   1'b1, 8'd0,   1'b0},   // cleared history, flat window
      {8'd255, 1'b1, 8'd255, 1'b0},   // lone bright pixel saturates
      {8'd255, 1'b1, 8'd255, 1'b0},
      {8'd0,   1'b0, 9'd0},
      {8'd1,   1'b0, 9'd0},
      {8'd128, 1'b0, 9'd0},
      {8'd127, 1'b0, 9'd0},
      {8'h55,  1'b0, 9'd0},
      {8'hAA,  1'b0, 9'd0},           // first window made of real pixels
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b0, 9'd0},
      {8'd100, 1'b1, 8'd0,   1'b1},   // window all one level, no gradient
      {8'd0,   1'b0, 9'd0},
      {8'd255, 1'b0, 9'd0},
      {8'd0,   1'b0, 9'd0},
      {8'd255, 1'b0, 9'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] pixel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] magnitude
   logic        rsp_tuser;            // [0] window_full
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state: two line delays, 3x3 window, write position, fill count
   logic [7:0] row_above [MAX_W];
   logic [7:0] row_two_above [MAX_W];
   logic [7:0] win [3][3];
   int unsigned hist_ptr = 0;
   int unsigned pixels_seen = 0;
   logic [sem_pkg::LINE_WIDTH_W-1:0] width_reg = sem_pkg::LINE_WIDTH_RESET;

   magnitude_type magnitude_queue [$];
   int failures = 0;
   int items_sent = 0;
   int sender_calm = 0;
   int receiver_calm = 0;
   int level = 128;

   sobel_edge_magnitude dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // wait cycles for one request, with calm stretches of no idling
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // pixel content: noise, slow ramps, flat steps or black and white
   function automatic logic [7:0] next_pixel(input pixel_style_type style);
      case (style)
         PX_SMOOTH: begin
            level = level + int'($urandom_range(0, 10)) - 5;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            return 8'(level);
         end
         PX_STEPS: begin
            if (level > 253 || $urandom_range(0, 11) == 0) level = $urandom_range(0, 253);
            return 8'(level + int'($urandom_range(0, 2)));
         end
         PX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // advance the predictor by one pixel and return the expected result
   function automatic magnitude_type predict_magnitude(input logic [7:0] px);
      int w, gx, gy, sq, root, r;
      logic [7:0] above, two_above;
      magnitude_type res;
      w = int'(width_reg);
      if (w < sem_pkg::MIN_WIDTH) w = sem_pkg::MIN_WIDTH;
      if (w > MAX_W) w = MAX_W;
      if (hist_ptr >= w) hist_ptr = 0;
      // line delays
      above = row_above[hist_ptr];
      two_above = row_two_above[hist_ptr];
      row_two_above[hist_ptr] = above;
      row_above[hist_ptr] = px;
      hist_ptr = (hist_ptr + 1 >= w) ? 0 : hist_ptr + 1;
      // window shift, newest column on the right
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = two_above;
      win[1][2] = above;
      win[2][2] = px;
      if (pixels_seen < FILL_LIMIT) pixels_seen++;
      // sobel kernels
      gx = (int'(win[0][2]) - int'(win[0][0]))
         + 2 * (int'(win[1][2]) - int'(win[1][0]))
         + (int'(win[2][2]) - int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      sq = gx * gx + gy * gy;
      if (sq >= 65536) begin
         res.magnitude = sem_pkg::MAG_MAX;
      end else begin
         root = 0;
         while ((root + 1) * (root + 1) <= sq) root++;
         res.magnitude = 8'(root);
      end
      res.window_full = (pixels_seen >= 2 * w + 3);
      return res;
   endfunction

   // one csr access: optional write, then a read-back of line_width
   task automatic csr_access(input bit do_write,
                             input logic [sem_pkg::LINE_WIDTH_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= do_write;
      csr_paddr <= CSR_LINE_WIDTH_ADDR;
      csr_pwdata <= {20'($urandom()), value};
      if (do_write) begin
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (csr_pready !== 1'b1);
         width_reg = value;
         // straight into the setup of the read-back
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[sem_pkg::LINE_WIDTH_W-1:0] !== value) begin
         $display("%0t: line_width read expected %0d actual %0d",
                  $time, value, csr_prdata[sem_pkg::LINE_WIDTH_W-1:0]);
         failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // drive one request; the valid stays high when the next one follows at once
   task automatic send_pixel(input logic [7:0] px, input logic typed,
                             input magnitude_type typed_result);
      int gap;
      magnitude_type predicted;
      gap = draw_wait(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_magnitude(px);
      magnitude_queue.push_back(typed ? typed_result : predicted);
      items_sent++;
   endtask

   // hold off until every expected result is in, then let the block settle
   task automatic wait_for_results();
      int n;
      for (n = 0; n < DRAIN_LIMIT && magnitude_queue.size() != 0; n++) @(posedge clock);
      if (magnitude_queue.size() != 0) begin
         $display("%0t: %0d results never arrived, next expected magnitude %0d window_full %0b",
                  $time, magnitude_queue.size(), magnitude_queue[0].magnitude,
                  magnitude_queue[0].window_full);
         failures++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // rewrite the width on an idle block and stream a run of pixels
   task automatic run_phase(input logic [sem_pkg::LINE_WIDTH_W-1:0] value, input int count,
                            input pixel_style_type style);
      int i;
      csr_access(1'b1, value);
      for (i = 0; i < count; i++) send_pixel(next_pixel(style), 1'b0, '0);
      req_tvalid <= 1'b0;
      wait_for_results();
   endtask

   // result side: random stalls, field by field compare with the oldest expectation
   initial begin : result_side
      int stall;
      magnitude_type want;
      forever begin
         stall = draw_wait(receiver_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (magnitude_queue.size() == 0) begin
            $display("%0t: unexpected result, magnitude %0d window_full %0b",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = magnitude_queue.pop_front();
            if (rsp_tdata !== want.magnitude) begin
               $display("%0t: magnitude expected %0d actual %0d",
                        $time, want.magnitude, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== want.window_full) begin
               $display("%0t: window_full expected %0b actual %0b",
                        $time, want.window_full, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // request side and overall sequence
   initial begin : stimulus
      int i, w, eff, count;
      pixel_style_type style;
      foreach (row_above[k]) begin
         row_above[k] = 8'd0;
         row_two_above[k] = 8'd0;
      end
      foreach (win[r, c]) win[r][c] = 8'd0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset value, then the narrowest line for the directed part
      csr_access(1'b0, sem_pkg::LINE_WIDTH_RESET);
      csr_access(1'b1, 12'd3);
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_pixel(DIRECTED[i].pixel, DIRECTED[i].typed, DIRECTED[i].result);
      end
      req_tvalid <= 1'b0;
      wait_for_results();

      // width extremes and clamping, history kept across each change
      run_phase(12'd0, 40, PX_SMOOTH);
      run_phase(12'd1, 30, PX_NOISE);
      run_phase(12'd2, 30, PX_STEPS);
      run_phase(12'd4095, 60, PX_SMOOTH);
      run_phase(12'd2048, 40, PX_NOISE);
      run_phase(12'd2047, 30, PX_STEPS);
      run_phase(sem_pkg::LINE_WIDTH_RESET, 30, PX_SMOOTH);
      run_phase(12'd4, 60, PX_BINARY);
      run_phase(12'd3, 60, PX_SMOOTH);

      // random widths, mostly narrow so that full windows come often
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19)) inside
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(2040, 4095);
            2, 3:    w = $urandom_range(49, 200);
            default: w = $urandom_range(3, 48);
         endcase
         eff = (w < sem_pkg::MIN_WIDTH) ? sem_pkg::MIN_WIDTH : ((w > MAX_W) ? MAX_W : w);
         count = (eff <= 48) ? $urandom_range(eff, 3 * eff + 10) : $urandom_range(20, 60);
         style = pixel_style_type'($urandom_range(0, 3));
         run_phase(12'(w), count, style);
      end

      if (failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #6_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

### sim.f
src/sem_pkg.sv
src/sem_front.sv
src/sem_queue.sv
src/sem_back.sv
src/sobel_edge_magnitude.sv
verif/tb.sv
